// File: hdl/rrx_pkg.sv
// ----------------------------------------------------------------------------
// rrx_pkg
// Shared types and constants for the receive ring with a held read request.
// ----------------------------------------------------------------------------
package rrx_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_READ_DEF   = 64;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Depth of the job queue between the command front and the drain back.
  localparam int JOB_Q_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX    = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_t;

endpackage

// File: hdl/rrx_ram.sv
// ----------------------------------------------------------------------------
// rrx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rrx_queue.sv
// ----------------------------------------------------------------------------
// rrx_queue
// Short register queue that carries drain and error jobs to the back end.
// ----------------------------------------------------------------------------
module rrx_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             room
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rptr_r];
  assign not_empty = (count_r != '0);
  assign room      = (count_r < CW'(DEPTH));

  assert property (@(posedge clk) disable iff (!rst_n) push |-> count_r < CW'(DEPTH))
    else $error("job queue written while full");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_r != '0)
    else $error("job queue read while empty");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("job queue count lost a transfer");

endmodule

// File: hdl/rrx_front.sv
// ----------------------------------------------------------------------------
// rrx_front
// Command front end: keeps the ring indices and the held read, writes
// received bytes, and hands drain or error jobs to the queue.
// ----------------------------------------------------------------------------
module rrx_front import rrx_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_READ   = MAX_READ_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [CMD_W-1:0]                     in_command,
  input  logic [BYTE_W-1:0]                    in_rx_byte,
  input  logic [LEN_W-1:0]                     in_read_length,
  input  logic                                 back_busy,
  input  logic                                 q_room,
  output logic                                 job_push,
  output logic [$clog2(RING_DEPTH)+LEN_W:0]    job_data,
  output logic                                 ram_we,
  output logic [$clog2(RING_DEPTH)-1:0]        ram_waddr,
  output logic [BYTE_W-1:0]                    ram_wdata
);

  localparam int IW   = $clog2(RING_DEPTH);
  localparam int CW   = IW + 1;
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_READ);

  logic [IW-1:0]    w_r, w_nxt;
  logic [IW-1:0]    r_r, r_nxt;
  logic             pend_r, pend_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;

  cmd_t             cmd;
  logic             accept;
  logic [IW-1:0]    w_inc;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] len_sel;
  logic [CMPW-1:0]  fill_now;
  logic [CMPW-1:0]  fill_rx;
  logic [CMPW:0]    r_sum;
  logic [IW-1:0]    r_adv;
  logic             job_err;

  // Number of buffered bytes between a write index and a read index.
  function automatic logic [CMPW-1:0] ring_fill(input logic [IW-1:0] wi,
                                                input logic [IW-1:0] ri);
    logic [CW-1:0] diff;
    if (wi >= ri) begin
      diff = {1'b0, wi} - {1'b0, ri};
    end else begin
      diff = {1'b0, wi} + CW'(RING_DEPTH) - {1'b0, ri};
    end
    return CMPW'(diff);
  endfunction

  always_comb begin
    cmd      = cmd_t'(in_command);
    // A stored byte must not land in a slot that an outstanding drain still reads.
    in_stall = !q_room || ((cmd == CMD_RX) && back_busy);
    accept   = in_valid && !in_stall;

    w_inc    = (w_r == IW'(RING_DEPTH - 1)) ? '0 : w_r + 1'b1;
    len_sat  = (in_read_length > MAX_LEN) ? MAX_LEN : in_read_length;
    len_sel  = (cmd == CMD_RX) ? plen_r : len_sat;
    fill_now = ring_fill(w_r, r_r);
    fill_rx  = ring_fill(w_inc, r_r);

    // The drained length never exceeds the fill, so one subtract wraps it.
    r_sum = {1'b0, CMPW'(r_r)} + (CMPW + 1)'(len_sel);
    if (r_sum >= (CMPW + 1)'(RING_DEPTH)) begin
      r_adv = IW'(r_sum - (CMPW + 1)'(RING_DEPTH));
    end else begin
      r_adv = IW'(r_sum);
    end

    w_nxt     = w_r;
    r_nxt     = r_r;
    pend_nxt  = pend_r;
    plen_nxt  = plen_r;
    job_push  = 1'b0;
    job_err   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = in_rx_byte;

    if (accept) begin
      case (cmd)
        CMD_RX: begin
          ram_we = 1'b1;
          if (w_inc == r_r) begin
            // Overflow: the ring empties and a held read fails.
            w_nxt = '0;
            r_nxt = '0;
            if (pend_r) begin
              job_push = 1'b1;
              job_err  = 1'b1;
              pend_nxt = 1'b0;
              plen_nxt = '0;
            end
          end else begin
            w_nxt = w_inc;
            if (pend_r && plen_r != '0 && fill_rx >= CMPW'(plen_r)) begin
              job_push = 1'b1;
              r_nxt    = r_adv;
              pend_nxt = 1'b0;
              plen_nxt = '0;
            end
          end
        end
        CMD_READ: begin
          if (in_read_length != '0) begin
            if (fill_now >= CMPW'(len_sat)) begin
              job_push = 1'b1;
              r_nxt    = r_adv;
            end else begin
              pend_nxt = 1'b1;
              plen_nxt = len_sat;
            end
          end
        end
        CMD_FLUSH: begin
          r_nxt = w_r;
        end
        CMD_ABORT: begin
          w_nxt = '0;
          r_nxt = '0;
          if (pend_r) begin
            job_push = 1'b1;
            job_err  = 1'b1;
            pend_nxt = 1'b0;
            plen_nxt = '0;
          end
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
    end

    job_data = {job_err, r_r, len_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= '0;
      r_r    <= '0;
      pend_r <= 1'b0;
      plen_r <= '0;
    end else begin
      w_r    <= w_nxt;
      r_r    <= r_nxt;
      pend_r <= pend_nxt;
      plen_r <= plen_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   pend_r |-> (plen_r != '0) && (plen_r <= MAX_LEN))
    else $error("held read has an out-of-range length");
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> !back_busy)
    else $error("ring written while a drain is outstanding");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (job_push && !job_err) |-> (len_sel != '0) && (len_sel <= MAX_LEN))
    else $error("drain job with an illegal length");

endmodule

// File: hdl/rrx_back.sv
// ----------------------------------------------------------------------------
// rrx_back
// Drain back end: takes jobs from the queue, reads the ring byte by byte and
// presents results through an output register.
// ----------------------------------------------------------------------------
module rrx_back import rrx_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  logic [$clog2(RING_DEPTH)+LEN_W:0]    q_data,
  output logic                                 q_pop,
  output logic                                 busy,
  output logic                                 ram_re,
  output logic [$clog2(RING_DEPTH)-1:0]        ram_raddr,
  input  logic [BYTE_W-1:0]                    ram_rdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [BYTE_W-1:0]                    out_data_byte,
  output logic                                 out_status,
  output logic                                 out_last
);

  localparam int IW = $clog2(RING_DEPTH);

  back_state_t      state_r, state_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             job_err;
  logic [IW-1:0]    job_start;
  logic [LEN_W-1:0] job_len;
  logic             out_free;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
    return (a == IW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign job_err   = q_data[IW+LEN_W];
  assign job_start = q_data[IW+LEN_W-1:LEN_W];
  assign job_len   = q_data[LEN_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign busy      = (state_r != BK_IDLE) || q_valid;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (job_err) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = '0;
            out_status_nxt = 1'b1;
            out_last_nxt   = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = job_start;
            addr_nxt  = ring_inc(job_start);
            rem_nxt   = job_len;
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        // The read data stays put until the next read is issued.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = ram_rdata;
          out_status_nxt = 1'b0;
          out_last_nxt   = (rem_r == LEN_W'(1));
          if (rem_r == LEN_W'(1)) begin
            rem_nxt   = '0;
            state_nxt = BK_IDLE;
          end else begin
            ram_re   = 1'b1;
            addr_nxt = ring_inc(addr_r);
            rem_nxt  = rem_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && out_status_r) |-> (out_data_r == '0) && out_last_r)
    else $error("error result without zero data and last");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == BK_EMIT) |-> (rem_r != '0))
    else $error("drain running with no bytes left");
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_pop |-> (state_r == BK_IDLE))
    else $error("job taken while a drain is running");

endmodule

// File: hdl/uart_rx_ring_with_pending_read_top.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_with_pending_read_top
// Receive ring buffer with a held threshold read, flush and abort.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  command, rx_byte, read_length
//   out_     output     out_valid/out_stall data_byte, status, last
//
// A command is taken each cycle while the job queue has room; a received
// byte is held off while a drain or error job is still outstanding.
// A drain of N bytes passes the job queue and the registered read port of the
// ring RAM, then gives one byte per cycle while the result side does not stall.
// An error result passes the job queue and the output register.
// Reset clears the indices and the held read; the ring RAM is not cleared.
// A stall on the result side holds the output register and backs up the queue.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_pending_read_top import rrx_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_READ   = MAX_READ_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic [LEN_W-1:0]  in_read_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_status,
  output logic              out_last
);

  localparam int IW    = $clog2(RING_DEPTH);
  localparam int JOB_W = 1 + IW + LEN_W;

  logic              back_busy;
  logic              q_room;
  logic              q_valid;
  logic              job_push;
  logic              job_pop;
  logic [JOB_W-1:0]  job_in;
  logic [JOB_W-1:0]  job_out;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  rrx_front #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .in_read_length (in_read_length),
    .back_busy      (back_busy),
    .q_room         (q_room),
    .job_push       (job_push),
    .job_data       (job_in),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  rrx_queue #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .head_data (job_out),
    .not_empty (q_valid),
    .room      (q_room)
  );

  rrx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrx_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (job_out),
    .q_pop         (job_pop),
    .busy          (back_busy),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

// File: verif/rrx_result_checker.sv
// ----------------------------------------------------------------------------
// rrx_result_checker
// Watches both channels of the receive ring, predicts every result transfer
// from the accepted commands and compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrx_result_checker import rrx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic [LEN_W-1:0]  in_read_length,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] out_data_byte,
  input  logic              out_status,
  input  logic              out_last,
  output int                mismatches,
  output int                awaited
);

  localparam int IDX_W = $clog2(RING_DEPTH_DEF);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              status;
    logic              last;
  } rx_result_t;

  logic [BYTE_W-1:0] ring_copy [RING_DEPTH_DEF];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic              held_read;
  int                held_len;
  rx_result_t        owed_results [$];
  int                results_seen;

  initial begin
    mismatches   = 0;
    awaited      = 0;
    results_seen = 0;
    wr_ptr       = '0;
    rd_ptr       = '0;
    held_read    = 1'b0;
    held_len     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d (%0t): %s", results_seen, $time, msg);
    mismatches++;
  endtask

  function automatic int fill_level();
    logic [IDX_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  // Queue a run of bytes oldest first; only the final byte carries last.
  task automatic queue_run(input int run_len);
    rx_result_t r;
    for (int i = 0; i < run_len; i++) begin
      r.data_byte = ring_copy[rd_ptr];
      r.status    = 1'b0;
      r.last      = (i == run_len - 1);
      owed_results.push_back(r);
      rd_ptr = rd_ptr + 1'b1;
    end
  endtask

  task automatic end_held_read();
    rx_result_t r;
    if (held_read) begin
      held_read   = 1'b0;
      held_len    = 0;
      r.data_byte = '0;
      r.status    = 1'b1;
      r.last      = 1'b1;
      owed_results.push_back(r);
    end
  endtask

  task automatic apply_command(input cmd_t cmd, input logic [BYTE_W-1:0] rx,
                               input logic [LEN_W-1:0] req_len);
    int want;
    case (cmd)
      CMD_RX: begin
        ring_copy[wr_ptr] = rx;
        wr_ptr = wr_ptr + 1'b1;
        // The write side caught up with the read side: the ring overflowed.
        if (wr_ptr == rd_ptr) begin
          wr_ptr = '0;
          rd_ptr = '0;
          end_held_read();
        end else if (held_read && held_len != 0 && fill_level() >= held_len) begin
          want      = held_len;
          held_read = 1'b0;
          held_len  = 0;
          queue_run(want);
        end
      end
      CMD_READ: begin
        if (req_len != '0) begin
          want = (int'(req_len) > MAX_READ_DEF) ? MAX_READ_DEF : int'(req_len);
          if (fill_level() >= want) begin
            queue_run(want);
          end else begin
            held_read = 1'b1;
            held_len  = want;
          end
        end
      end
      CMD_FLUSH: begin
        rd_ptr = wr_ptr;
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
        end_held_read();
      end
    endcase
  endtask

  always @(posedge clk) begin
    rx_result_t want_r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_command(cmd_t'(in_command), in_rx_byte, in_read_length);
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer data=%h status=%b last=%b",
                                    out_data_byte, out_status, out_last));
        end else begin
          want_r = owed_results.pop_front();
          if (out_data_byte !== want_r.data_byte) begin
            report_mismatch($sformatf("data_byte %h, expected %h",
                                      out_data_byte, want_r.data_byte));
          end
          if (out_status !== want_r.status) begin
            report_mismatch($sformatf("status %b, expected %b", out_status, want_r.status));
          end
          if (out_last !== want_r.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_last, want_r.last));
          end
        end
        results_seen++;
      end
    end
    awaited <= owed_results.size();
  end

endmodule

// File: verif/uart_rx_ring_with_pending_read_top_test.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_with_pending_read_top_test
// Drives commands into the receive ring under several idle and stall mixes,
// with a directed opening, a long output hold-off and an overflow burst; the
// result checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_rx_ring_with_pending_read_top_test;
  import rrx_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [BYTE_W-1:0] in_rx_byte;
  logic [LEN_W-1:0]  in_read_length;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_status;
  logic              out_last;

  int mismatches;
  int awaited;
  int send_idle_pct;
  int stall_pct;
  int hold_left;

  uart_rx_ring_with_pending_read_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .in_read_length (in_read_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  rrx_result_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .in_read_length (in_read_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_status     (out_status),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("uart_rx_ring_with_pending_read_top_test failed");
    $finish;
  end

  // Result side: a long hold-off counts down first, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one command and returns at the edge where it transfers. The stall
  // is sampled at the falling edge, where it has settled for the coming edge.
  task automatic send_item(input cmd_t cmd, input logic [BYTE_W-1:0] rx,
                           input logic [LEN_W-1:0] req_len);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_rx_byte     <= rx;
    in_read_length <= req_len;
    forever begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
      if (took) break;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  // Mostly stores and short reads with random content; flush and abort now
  // and then, and a share of full-range lengths including zero and oversize.
  task automatic rand_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_item(CMD_RX, BYTE_W'($urandom), LEN_W'($urandom));
    end else if (pick < 85) begin
      if ($urandom_range(9) == 0) begin
        send_item(CMD_READ, BYTE_W'($urandom), LEN_W'($urandom_range(0, 127)));
      end else begin
        send_item(CMD_READ, BYTE_W'($urandom), LEN_W'($urandom_range(1, 12)));
      end
    end else if (pick < 92) begin
      send_item(CMD_FLUSH, BYTE_W'($urandom), LEN_W'($urandom));
    end else begin
      send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  int idle_mix  [4] = '{0, 49, 0, 13};
  int stall_mix [4] = '{0, 0, 49, 13};

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_RX;
    in_rx_byte     = '0;
    in_read_length = '0;
    out_stall      = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: ignored zero length, held read ended by abort, abort
    // with nothing held, immediate read, oversize length, replaced held read,
    // drain after a store, flush keeping the held read, immediate read while
    // another is held.
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd0);
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd5);
    send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
    send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
    send_item(CMD_RX,    8'h00,             LEN_W'($urandom));
    send_item(CMD_RX,    8'hFF,             LEN_W'($urandom));
    send_item(CMD_RX,    8'hA5,             LEN_W'($urandom));
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd2);
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd127);
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd3);
    send_item(CMD_RX,    8'h5A,             LEN_W'($urandom));
    send_item(CMD_RX,    8'h01,             LEN_W'($urandom));
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd1);
    send_item(CMD_FLUSH, BYTE_W'($urandom), LEN_W'($urandom));
    send_item(CMD_RX,    8'h80,             LEN_W'($urandom));
    send_item(CMD_RX,    8'h7F,             LEN_W'($urandom));
    send_item(CMD_RX,    8'h33,             LEN_W'($urandom));
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd4);
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd1);
    send_item(CMD_FLUSH, BYTE_W'($urandom), LEN_W'($urandom));
    send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
    send_item(CMD_RX,    8'h55,             LEN_W'($urandom));
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd64);
    send_item(CMD_READ,  BYTE_W'($urandom), 7'd127);
    send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
    wait_drained();

    // Hold the result side off while short reads pile up in the job queue
    // until the input stalls.
    hold_left <= 200;
    for (int i = 0; i < 10; i++) send_item(CMD_RX, BYTE_W'($urandom), LEN_W'($urandom));
    for (int i = 0; i < 7; i++) send_item(CMD_READ, BYTE_W'($urandom), 7'd1);
    send_item(CMD_RX, BYTE_W'($urandom), LEN_W'($urandom));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      for (int i = 0; i < 8; i++) rand_item();
      if (p == 3) begin
        // A full ring of stores without a read wraps the write side onto
        // the read side.
        send_item(CMD_ABORT, BYTE_W'($urandom), LEN_W'($urandom));
        for (int i = 0; i < RING_DEPTH_DEF; i++) begin
          send_item(CMD_RX, BYTE_W'($urandom), LEN_W'($urandom));
        end
        send_item(CMD_READ, BYTE_W'($urandom), 7'd1);
        send_item(CMD_RX, BYTE_W'($urandom), LEN_W'($urandom));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("uart_rx_ring_with_pending_read_top_test passed");
    end else begin
      $display("uart_rx_ring_with_pending_read_top_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rrx_pkg.sv
hdl/rrx_ram.sv
hdl/rrx_queue.sv
hdl/rrx_front.sv
hdl/rrx_back.sv
hdl/uart_rx_ring_with_pending_read_top.sv
verif/rrx_result_checker.sv
verif/uart_rx_ring_with_pending_read_top_test.sv
